// File: hw/rtl/ogru_pkg.sv
// Package: shared types and constants of the occupancy grid ray update block.
package ogru_pkg;

  localparam int unsigned CoordW   = 8;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned WalkW    = 9;

  localparam logic [CfgIdxW-1:0] RegGridWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGridHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHitOdds    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMissOdds   = 2'd3;

  localparam logic OpRay  = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic signed [7:0] CellUnknown  = -8'sd1;
  localparam logic signed [7:0] ReadErrValue = -8'sd2;
  localparam logic signed [8:0] OddsCeiling  = 9'sd100;

  // Request item.
  typedef struct packed {
    logic              opcode;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic              hit;
  } req_t;

  // Result item.
  typedef struct packed {
    logic signed [7:0] cell_value;
    logic [WalkW-1:0]  cells_walked;
  } rsp_t;

  // Cell operation applied by the datapath.
  typedef enum logic [1:0] {
    CELL_ADD_HIT,
    CELL_SUB_MISS,
    CELL_READ
  } cell_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_HIT_RD,
    ST_HIT_WR,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_HIT2_RD,
    ST_HIT2_WR,
    ST_FIN_RD,
    ST_FIN_WAIT,
    ST_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic     load;       // capture the request
    logic     setup;      // prepare the line walk
    logic     sel_walk;   // address the current line cell, else the end cell (the start cell on a read)
    logic     mem_rd;
    logic     mem_wr;
    cell_op_e op;
    logic     step;       // advance the line walk
    logic     clear_wr;   // write the clear pattern
    logic     out_load;   // capture the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_read;
    logic hit;
    logic walk_last;
    logic clear_done;
  } sts_t;

endpackage

// File: hw/rtl/ogru_if.sv
// Interface: valid/ready channel carrying one payload.
interface ogru_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/occupancy_grid_ray_update.sv
// Top level: occupancy grid ray update with configuration registers.
//
//  channel  dir  signals                      payload
//  in_ch    in   valid, ready                 opcode, start/end x/y, hit
//  out_ch   out  valid, ready                 cell_value, cells_walked
//  cfg      in   cfg_we_i, cfg_idx_i, data    grid size, hit/miss odds
//
// A ray reads then writes each line cell through the one grid RAM port; a hit
// also reads and writes the end cell before the walk and again after it, and
// idle, setup, final read and result load make up the rest. A read takes idle,
// setup, final read and result load. After reset the grid RAM is cleared one
// cell a cycle, all MAX_WIDTH*MAX_HEIGHT cells, before the first transfer is taken.
// One item at a time; a result waits in the output register while stalled.
module occupancy_grid_ray_update #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ogru_if.sink                          in_ch,
  ogru_if.source                        out_ch,
  input  logic                          cfg_we_i,
  input  logic [ogru_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ogru_pkg::CfgDataW-1:0] cfg_data_i
);
  import ogru_pkg::*;

  logic [CfgDataW-1:0] grid_width_q, grid_height_q;
  logic [6:0]          hit_odds_q, miss_odds_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CfgDataW'(256);
      grid_height_q <= CfgDataW'(256);
      hit_odds_q    <= 7'd10;
      miss_odds_q   <= 7'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGridWidth:  grid_width_q  <= cfg_data_i;
        RegGridHeight: grid_height_q <= cfg_data_i;
        RegHitOdds:    hit_odds_q    <= cfg_data_i[6:0];
        RegMissOdds:   miss_odds_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  sts_t sts;

  ogru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ogru_dp #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (in_ch.data),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .hit_odds_i    (hit_odds_q),
    .miss_odds_i   (miss_odds_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rsp_o         (out_ch.data)
  );
endmodule

// File: hw/rtl/ogru_ram.sv
// Generic single-port RAM with registered read.
module ogru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One access per cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: hw/rtl/ogru_ctrl.sv
// Controller: sequences clearing, ray updates and reads.
module ogru_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ogru_pkg::sts_t  sts_i,
  output ogru_pkg::cmd_t  cmd_o
);
  import ogru_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.op    = CELL_READ;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        if (sts_i.is_read) begin
          state_d = ST_FIN_RD;
        end else if (sts_i.hit) begin
          state_d = ST_HIT_RD;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_HIT_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_HIT_WR;
      end
      ST_HIT_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.op     = CELL_ADD_HIT;
        state_d      = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        cmd_o.sel_walk = 1'b1;
        cmd_o.mem_rd   = 1'b1;
        state_d        = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        cmd_o.sel_walk = 1'b1;
        cmd_o.mem_wr   = 1'b1;
        cmd_o.op       = CELL_SUB_MISS;
        cmd_o.step     = 1'b1;
        if (!sts_i.walk_last) begin
          state_d = ST_WALK_RD;
        end else if (sts_i.hit) begin
          state_d = ST_HIT2_RD;
        end else begin
          state_d = ST_FIN_RD;
        end
      end
      ST_HIT2_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_HIT2_WR;
      end
      ST_HIT2_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.op     = CELL_ADD_HIT;
        state_d      = ST_FIN_RD;
      end
      ST_FIN_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
endmodule

// File: hw/rtl/ogru_dp.sv
// Datapath: request registers, line walker, cell arithmetic and grid memory.
module ogru_dp #(
  parameter int unsigned MaxWidth  = 256,
  parameter int unsigned MaxHeight = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ogru_pkg::req_t                req_i,
  input  logic [ogru_pkg::CfgDataW-1:0] grid_width_i,
  input  logic [ogru_pkg::CfgDataW-1:0] grid_height_i,
  input  logic [6:0]                    hit_odds_i,
  input  logic [6:0]                    miss_odds_i,
  input  ogru_pkg::cmd_t                cmd_i,
  output ogru_pkg::sts_t                sts_o,
  output ogru_pkg::rsp_t                rsp_o
);
  import ogru_pkg::*;

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned DimW  = $clog2(MaxWidth + 1) > $clog2(MaxHeight + 1) ?
                                  $clog2(MaxWidth + 1) : $clog2(MaxHeight + 1);
  localparam int unsigned EW    = DimW + 2;

  // Effective grid size, limited to 1..MAX.
  logic [DimW-1:0] eff_w, eff_h;
  always_comb begin
    if (grid_width_i == '0) begin
      eff_w = DimW'(1);
    end else if ({{(DimW + 1){1'b0}}, grid_width_i} > (DimW + CfgDataW + 1)'(MaxWidth)) begin
      eff_w = DimW'(MaxWidth);
    end else begin
      eff_w = DimW'(grid_width_i);
    end
    if (grid_height_i == '0) begin
      eff_h = DimW'(1);
    end else if ({{(DimW + 1){1'b0}}, grid_height_i} > (DimW + CfgDataW + 1)'(MaxHeight)) begin
      eff_h = DimW'(MaxHeight);
    end else begin
      eff_h = DimW'(grid_height_i);
    end
  end

  req_t req_q;
  logic [DimW-1:0] sx_c, sy_c, ex_c, ey_c, wm1, hm1;

  assign wm1 = eff_w - DimW'(1);
  assign hm1 = eff_h - DimW'(1);

  function automatic logic [DimW-1:0] clampc(input logic [CoordW-1:0] v,
                                             input logic [DimW-1:0] hi);
    logic [DimW+CoordW-1:0] ve;
    ve = {{DimW{1'b0}}, v};
    return (ve > (DimW + CoordW)'(hi)) ? hi : DimW'(ve);
  endfunction

  assign sx_c = clampc(req_q.start_x, wm1);
  assign sy_c = clampc(req_q.start_y, hm1);
  assign ex_c = clampc(req_q.end_x, wm1);
  assign ey_c = clampc(req_q.end_y, hm1);

  // Line walker registers: major/minor positions, error term, count of cells walked.
  logic [DimW-1:0]       ex_q, ey_q;
  logic                  steep_q, neg_q;
  logic [DimW-1:0]       major_q, minor_q, bx_q, dx_q, dy_q;
  logic signed [EW-1:0]  err_q;
  logic [WalkW-1:0]      walked_q;
  logic                  rd_ok_q;

  // Setup arithmetic.
  logic signed [EW-1:0] adx, ady;
  logic [DimW-1:0] absx, absy;
  logic steep;
  logic [DimW-1:0] ax, ay, bx, by;
  assign adx  = signed'(EW'(ex_c)) - signed'(EW'(sx_c));
  assign ady  = signed'(EW'(ey_c)) - signed'(EW'(sy_c));
  assign absx = adx[EW-1] ? DimW'(-adx) : DimW'(adx);
  assign absy = ady[EW-1] ? DimW'(-ady) : DimW'(ady);
  assign steep = absy > absx;

  always_comb begin
    logic [DimW-1:0] a0, a1, b0, b1;
    a0 = steep ? sy_c : sx_c;
    a1 = steep ? sx_c : sy_c;
    b0 = steep ? ey_c : ex_c;
    b1 = steep ? ex_c : ey_c;
    if (a0 > b0) begin
      ax = b0; ay = b1; bx = a0; by = a1;
    end else begin
      ax = a0; ay = a1; bx = b0; by = b1;
    end
  end

  logic signed [EW-1:0] err_dec;
  assign err_dec = err_q - signed'(EW'(dy_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.setup) begin
      ex_q     <= ex_c;
      ey_q     <= ey_c;
      steep_q  <= steep;
      major_q  <= ax;
      minor_q  <= ay;
      bx_q     <= bx;
      dx_q     <= bx - ax;
      dy_q     <= (by > ay) ? by - ay : ay - by;
      neg_q    <= ay > by;
      err_q    <= signed'(EW'((bx - ax) >> 1));
      walked_q <= '0;
      rd_ok_q  <= ({1'b0, req_q.start_x} < (CoordW + 1)'(eff_w)) &&
                  ({1'b0, req_q.start_y} < (CoordW + 1)'(eff_h));
    end else if (cmd_i.step) begin
      major_q  <= major_q + DimW'(1);
      walked_q <= walked_q + WalkW'(1);
      if (err_dec < 0) begin
        minor_q <= neg_q ? minor_q - DimW'(1) : minor_q + DimW'(1);
        err_q   <= err_dec + signed'(EW'(dx_q));
      end else begin
        err_q <= err_dec;
      end
    end
  end

  // Clearing sweep address.
  logic [AddrW:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr && !clr_q[AddrW]) begin
      clr_q <= clr_q + (AddrW + 1)'(1);
    end
  end

  // Cell address: row * width + column.
  logic [DimW-1:0] col, row;
  logic [2*DimW-1:0] lin;
  logic [AddrW-1:0] addr;
  always_comb begin
    if (cmd_i.sel_walk) begin
      col = steep_q ? minor_q : major_q;
      row = steep_q ? major_q : minor_q;
    end else if (req_q.opcode == OpRead) begin
      col = DimW'(req_q.start_x);
      row = DimW'(req_q.start_y);
    end else begin
      col = ex_q;
      row = ey_q;
    end
    lin = row * eff_w + (2*DimW)'(col);
    addr = cmd_i.clear_wr ? clr_q[AddrW-1:0] : AddrW'(lin);
  end

  // Cell arithmetic on the value read in the previous cycle.
  logic [7:0] rdata, wdata;
  logic signed [8:0] v;
  always_comb begin
    v = signed'({rdata[7], rdata});
    wdata = rdata;
    case (cmd_i.op)
      CELL_ADD_HIT: begin
        if (v <= OddsCeiling - signed'({2'b00, hit_odds_i})) begin
          wdata = rdata + {1'b0, hit_odds_i};
        end
      end
      CELL_SUB_MISS: begin
        if (v >= signed'({2'b00, miss_odds_i})) begin
          wdata = rdata - {1'b0, miss_odds_i};
        end
      end
      default: begin
        wdata = rdata;
      end
    endcase
    if (cmd_i.clear_wr) begin
      wdata = CellUnknown;
    end
  end

  ogru_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_wr || (cmd_i.clear_wr && !clr_q[AddrW])),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (req_q.opcode == OpRead) begin
        rsp_o.cell_value   <= rd_ok_q ? signed'(rdata) : ReadErrValue;
        rsp_o.cells_walked <= '0;
      end else begin
        rsp_o.cell_value   <= signed'(rdata);
        rsp_o.cells_walked <= walked_q;
      end
    end
  end

  assign sts_o.is_read    = req_q.opcode == OpRead;
  assign sts_o.hit        = req_q.hit;
  assign sts_o.walk_last  = major_q == bx_q;
  assign sts_o.clear_done = clr_q[AddrW];
endmodule

// File: sim/tb_top.sv
// Testbench of the occupancy grid ray update block, with a scoreboard and random stimulus.
`timescale 1ns / 1ps

module tb_top;
  import ogru_pkg::*;

  localparam int unsigned GridCells = 256 * 256;
  localparam int unsigned CycleLimit = 3000000;

  // Mirrors the grid and the registers, and checks every result in order.
  class odds_scoreboard;
    logic signed [7:0] odds_mem [GridCells];
    int unsigned width_reg, height_reg, hit_reg, miss_reg;
    rsp_t pending_rsp [$];
    int errors;
    int rays, reads, hit_rays, read_errs;

    function new();
      foreach (odds_mem[i]) odds_mem[i] = CellUnknown;
      width_reg = 256;
      height_reg = 256;
      hit_reg = 10;
      miss_reg = 5;
      errors = 0;
      rays = 0;
      reads = 0;
      hit_rays = 0;
      read_errs = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegGridWidth:  width_reg = val;
        RegGridHeight: height_reg = val;
        RegHitOdds:    hit_reg = val[6:0];
        RegMissOdds:   miss_reg = val[6:0];
        default: ;
      endcase
    endfunction

    function int eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > 256) return 256;
      return width_reg;
    endfunction

    function int eff_h();
      if (height_reg < 1) return 1;
      if (height_reg > 256) return 256;
      return height_reg;
    endfunction

    function int get_cell(int col, int row);
      return odds_mem[row * eff_w() + col];
    endfunction

    function void put_cell(int col, int row, int val);
      odds_mem[row * eff_w() + col] = val[7:0];
    endfunction

    function void bump_hit(int col, int row);
      int v;
      v = get_cell(col, row);
      if (v <= 100 - int'(hit_reg)) put_cell(col, row, v + int'(hit_reg));
    endfunction

    function void drop_miss(int col, int row);
      int v;
      v = get_cell(col, row);
      if (v >= int'(miss_reg)) put_cell(col, row, v - int'(miss_reg));
    endfunction

    // Bresenham walk from one cell to another, end included; returns the cell count.
    function int trace_line(int ax, int ay, int bx, int by);
      bit steep;
      int t, dx, dy, err, stp, minor, major, n;
      n = 0;
      steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
      if (steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = (by > ay) ? by - ay : ay - by;
      err = dx / 2;
      minor = ay;
      stp = (ay < by) ? 1 : -1;
      for (major = ax; major <= bx; major++) begin
        if (steep) drop_miss(minor, major);
        else drop_miss(major, minor);
        n++;
        err -= dy;
        if (err < 0) begin
          minor += stp;
          err += dx;
        end
      end
      return n;
    endfunction

    // Works out the result of an accepted request and queues it.
    function void note_request(req_t rq);
      int w, h, sx, sy, ex, ey, val, walked;
      rsp_t r;
      w = eff_w();
      h = eff_h();
      sx = rq.start_x;
      sy = rq.start_y;
      walked = 0;
      if (rq.opcode == OpRead) begin
        reads++;
        if (sx < w && sy < h) val = get_cell(sx, sy);
        else begin
          val = ReadErrValue;
          read_errs++;
        end
      end else begin
        rays++;
        ex = (int'(rq.end_x) > w - 1) ? w - 1 : rq.end_x;
        ey = (int'(rq.end_y) > h - 1) ? h - 1 : rq.end_y;
        sx = (sx > w - 1) ? w - 1 : sx;
        sy = (sy > h - 1) ? h - 1 : sy;
        if (rq.hit) begin
          hit_rays++;
          bump_hit(ex, ey);
        end
        walked = trace_line(sx, sy, ex, ey);
        if (rq.hit) bump_hit(ex, ey);
        val = get_cell(ex, ey);
      end
      r.cell_value = val[7:0];
      r.cells_walked = walked[WalkW-1:0];
      pending_rsp.push_back(r);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: result with nothing expected, got value %0d walked %0d",
                 $time, got.cell_value, got.cells_walked);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.cell_value !== want.cell_value) begin
        $display("%0t: cell_value expected %0d actual %0d",
                 $time, want.cell_value, got.cell_value);
        errors++;
      end
      if (got.cells_walked !== want.cells_walked) begin
        $display("%0t: cells_walked expected %0d actual %0d",
                 $time, want.cells_walked, got.cells_walked);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  bit no_idle = 1'b0;
  int unsigned cycles = 0;
  int stall_left = 0;

  ogru_if #(.payload_t(req_t)) in_ch ();
  ogru_if #(.payload_t(rsp_t)) out_ch ();

  odds_scoreboard sb = new();

  occupancy_grid_ray_update u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // The receiver stalls in random bursts, except in the last part of the run.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Presents one request and holds it until its transfer.
  task automatic send_req(req_t rq);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data = rq;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_request(rq);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_ray(int sx, int sy, int ex, int ey, bit hit);
    req_t rq;
    rq.opcode = OpRay;
    rq.start_x = CoordW'(sx);
    rq.start_y = CoordW'(sy);
    rq.end_x = CoordW'(ex);
    rq.end_y = CoordW'(ey);
    rq.hit = hit;
    send_req(rq);
  endtask

  task automatic send_read(int x, int y);
    req_t rq;
    rq.opcode = OpRead;
    rq.start_x = CoordW'(x);
    rq.start_y = CoordW'(y);
    // The ray fields carry noise on reads.
    rq.end_x = CoordW'($urandom());
    rq.end_y = CoordW'($urandom());
    rq.hit = 1'($urandom());
    send_req(rq);
  endtask

  // Waits until the block has delivered everything, then writes all four registers.
  task automatic write_regs(int w, int h, int hit, int miss);
    logic [CfgDataW-1:0] vals [4];
    wait (sb.pending_rsp.size() == 0);
    repeat (20) @(negedge clk_i);
    vals[0] = CfgDataW'(w);
    vals[1] = CfgDataW'(h);
    vals[2] = CfgDataW'(hit);
    vals[3] = CfgDataW'(miss);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i = 1'b1;
      cfg_idx_i = CfgIdxW'(i);
      cfg_data_i = vals[i];
      sb.set_reg(cfg_idx_i, cfg_data_i);
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  // Random coordinate, mostly near the grid in use, sometimes anywhere.
  function automatic int pick_coord(int lim);
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, (lim + 1 > 255) ? 255 : lim + 1);
  endfunction

  task automatic random_phase(int n);
    int w, h;
    w = sb.eff_w();
    h = sb.eff_h();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        send_read(pick_coord(w), pick_coord(h));
      end else if (w * h > 1024 && $urandom_range(0, 3) != 0) begin
        // Short rays inside a corner patch, so that cells are revisited often.
        send_ray($urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom_range(0, 15),
                 1'($urandom_range(0, 1)));
      end else begin
        send_ray(pick_coord(w), pick_coord(h), pick_coord(w), pick_coord(h),
                 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings: reads, extremes, hits, reversed and steep lines.
    send_read(0, 0);
    send_read(255, 255);
    send_ray(0, 0, 255, 255, 1'b1);
    send_ray(255, 255, 0, 0, 1'b1);
    send_ray(0, 0, 255, 255, 1'b0);
    send_ray(3, 0, 3, 9, 1'b1);
    send_ray(3, 9, 3, 0, 1'b1);
    send_ray(0, 5, 200, 7, 1'b1);
    send_ray(7, 7, 7, 7, 1'b1);
    send_read(7, 7);
    send_read(255, 255);

    // Small grid: reads out of range, clamped ends, big odds.
    write_regs(8, 6, 127, 127);
    send_read(8, 0);
    send_read(0, 6);
    send_ray(255, 255, 255, 255, 1'b1);
    send_ray(0, 0, 200, 100, 1'b1);
    send_read(7, 5);
    write_regs(8, 6, 100, 0);
    send_ray(255, 0, 0, 255, 1'b1);
    send_ray(0, 255, 255, 0, 1'b0);
    send_read(0, 5);
    send_read(7, 0);

    // Random phases over several settings, extremes among them.
    write_regs(0, 0, 100, 0);
    random_phase(40);
    write_regs(511, 300, 0, 127);
    random_phase(60);
    write_regs(16, 16, 30, 4);
    random_phase(70);
    write_regs(1, 256, 127, 10);
    random_phase(60);
    write_regs(256, 1, 50, 50);
    random_phase(60);
    write_regs(13, 9, 25, 7);
    random_phase(80);
    write_regs(256, 256, 10, 5);
    random_phase(60);
    write_regs(40, 30, 60, 2);
    no_idle = 1'b1;
    random_phase(100);

    wait (sb.pending_rsp.size() == 0);
    repeat (600) @(posedge clk_i);
    $display("Covered %0d rays (%0d with hits) and %0d reads (%0d outside the grid)",
             sb.rays, sb.hit_rays, sb.reads, sb.read_errs);
    $display("over eleven register settings, with random stalls on both channels.");
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: occupancy_grid_ray_update.f
hw/rtl/ogru_pkg.sv
hw/rtl/ogru_if.sv
hw/rtl/ogru_ram.sv
hw/rtl/ogru_ctrl.sv
hw/rtl/ogru_dp.sv
hw/rtl/occupancy_grid_ray_update.sv
sim/tb_top.sv
